>>> design/log_domain_add_accumulate_defines.svh
// Assertion helpers used by lda_back. Each expects i_clk and i_rst_n in scope.
`ifndef LOG_DOMAIN_ADD_ACCUMULATE_DEFINES_SVH
`define LOG_DOMAIN_ADD_ACCUMULATE_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define LDA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define LDA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/lda_pkg.sv
package lda_pkg;

    localparam int LDA_VALUE_WIDTH = 24;
    localparam int LDA_FRAC_BITS   = 16;
    localparam int LDA_QUEUE_DEPTH = 2;

    // Internal fixed point: Q.30
    localparam int LDA_IB   = 30;
    localparam int LDA_AW   = 34;                 // accumulator / multiplier A width
    localparam int LDA_BW   = 32;                 // multiplier B width
    localparam int LDA_PW   = LDA_AW + LDA_BW;    // product width
    localparam int LDA_SW   = 33;                 // 1 + 2^-d, unsigned
    localparam int LDA_KW   = LDA_VALUE_WIDTH - LDA_FRAC_BITS + 2;
    localparam int LDA_SUMW = LDA_AW + 1;
    localparam int LDA_CNT_W = 4;

    localparam int LDA_EXP_STEPS  = 5;
    localparam int LDA_LOG_STEPS  = 4;
    localparam int LDA_DIV_CYCLES = 16;           // two quotient bits per cycle

    localparam logic signed [LDA_AW-1:0] LDA_EXP_C0 = 34'sd1438308;
    localparam logic signed [LDA_AW-1:0] LDA_EXP_C1 = 34'sd10383914;
    localparam logic signed [LDA_AW-1:0] LDA_EXP_C2 = 34'sd59596329;
    localparam logic signed [LDA_AW-1:0] LDA_EXP_C3 = 34'sd257936533;
    localparam logic signed [LDA_AW-1:0] LDA_EXP_C4 = 34'sd744261139;
    localparam logic signed [LDA_AW-1:0] LDA_EXP_C5 = 34'sd1073741880;
    localparam logic signed [LDA_AW-1:0] LDA_LOG_C0 = 34'sd641277395;
    localparam logic signed [LDA_AW-1:0] LDA_LOG_C1 = 34'sd1032428977;
    localparam logic signed [LDA_AW-1:0] LDA_LOG_C2 = 34'sd3098164970;

    localparam logic [LDA_SW-1:0] LDA_ONE   = 33'd1073741824;
    localparam logic [LDA_SW-1:0] LDA_SQRT2 = 33'd1518500250;
    localparam logic signed [LDA_AW-1:0] LDA_ONE_S = 34'sd1073741824;
    localparam logic signed [LDA_PW-1:0] LDA_MUL_BIAS = LDA_PW'(64'd1 << (LDA_IB - 1));
    localparam logic signed [LDA_AW-1:0] LDA_OUT_BIAS =
        LDA_AW'(64'd1 << (LDA_IB - LDA_FRAC_BITS - 1));
    localparam logic [LDA_FRAC_BITS-1:0] LDA_HALF = {1'b1, {(LDA_FRAC_BITS-1){1'b0}}};

    localparam logic signed [LDA_VALUE_WIDTH-1:0] LDA_NEUTRAL =
        {1'b1, {(LDA_VALUE_WIDTH-1){1'b0}}};
    localparam logic signed [LDA_VALUE_WIDTH-1:0] LDA_MAXCODE =
        {1'b0, {(LDA_VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [LDA_VALUE_WIDTH-1:0] LDA_MINCODE = LDA_NEUTRAL + 1'b1;

    typedef struct packed {
        logic                              op;
        logic signed [LDA_VALUE_WIDTH-1:0] a;
        logic signed [LDA_VALUE_WIDTH-1:0] b;
        logic                              last;
    } t_in_item;

    typedef struct packed {
        logic signed [LDA_VALUE_WIDTH-1:0] result_value;
        logic                              is_sum;
    } t_out_item;

    typedef enum logic [1:0] {
        KIND_PAIR,
        KIND_ACC,
        KIND_ACC_LAST
    } t_kind;

    // hi/lo are ordered for pairs; for accumulates hi carries a
    typedef struct packed {
        t_kind                             kind;
        logic signed [LDA_VALUE_WIDTH-1:0] hi;
        logic signed [LDA_VALUE_WIDTH-1:0] lo;
    } t_task;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_RED,
        ST_EXP,
        ST_SCALE,
        ST_NORM,
        ST_DIV,
        ST_LOG,
        ST_FIN,
        ST_EMIT
    } t_back_state;

    // Addend after exp Horner step idx
    function automatic logic signed [LDA_AW-1:0] lda_exp_addend(
        input logic [LDA_CNT_W-1:0] idx
    );
        logic signed [LDA_AW-1:0] c;
        unique case (idx)
            4'd0:    c = LDA_EXP_C1;
            4'd1:    c = LDA_EXP_C2;
            4'd2:    c = LDA_EXP_C3;
            4'd3:    c = LDA_EXP_C4;
            4'd4:    c = LDA_EXP_C5;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

>>> design/lda_front.sv
module lda_front
    import lda_pkg::*;
(
    input  logic     i_push,
    input  t_in_item i_item,
    input  logic     i_q_full,
    output logic     o_full,
    output logic     o_task_push,
    output t_task    o_task
);

    logic a_ge_b;

    assign a_ge_b      = i_item.a >= i_item.b;
    assign o_full      = i_q_full;
    assign o_task_push = i_push && !i_q_full;

    // Order the pair here; accumulates are ordered against the sum later.
    always_comb begin
        if (i_item.op) begin
            o_task.kind = i_item.last ? KIND_ACC_LAST : KIND_ACC;
            o_task.hi   = i_item.a;
            o_task.lo   = i_item.b;
        end else begin
            o_task.kind = KIND_PAIR;
            o_task.hi   = a_ge_b ? i_item.a : i_item.b;
            o_task.lo   = a_ge_b ? i_item.b : i_item.a;
        end
    end

endmodule

>>> design/lda_queue.sv
module lda_queue
    import lda_pkg::*;
#(
    parameter int DEPTH = LDA_QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_task i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_task o_data,
    output logic  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_task          r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;
    logic           do_push, do_pop;

    assign o_full  = r_count == CW'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> design/lda_back.sv
`include "log_domain_add_accumulate_defines.svh"

module lda_back
    import lda_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_task     i_task,
    input  logic      i_task_empty,
    output logic      o_task_pop,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_item o_out
);

    localparam int W = LDA_VALUE_WIDTH;
    localparam int F = LDA_FRAC_BITS;

    t_back_state r_state, n_state;

    t_kind                    r_kind;
    logic signed [W-1:0]      r_hi, r_lo, n_hi, n_lo;
    logic signed [W-1:0]      r_sum, r_res;
    logic                     r_bypass;
    logic [LDA_KW-1:0]        r_k;
    logic signed [LDA_BW-1:0] r_f, r_y, r_y2;
    logic signed [LDA_AW-1:0] r_acc;
    logic signed [LDA_PW-1:0] r_prod;
    logic                     r_phase;
    logic [LDA_CNT_W-1:0]     r_cnt;
    logic [LDA_SW-1:0]        r_s;
    logic                     r_eflag, r_neg;
    logic [31:0]              r_den, r_rem, r_dvd, r_quo;
    t_out_item                r_out;
    logic                     r_out_valid;

    logic                     bypass;
    logic                     out_free;
    logic                     emit;

    // Reduction
    logic [W:0]               diff;
    logic [W-F:0]             q;
    logic [F-1:0]             rem;
    logic                     rnd_up;
    logic [LDA_KW-1:0]        k;
    logic [LDA_KW+F-1:0]      fdiff;
    logic signed [F:0]        fs;

    // Shared multiplier
    logic signed [LDA_AW-1:0] mul_a;
    logic signed [LDA_BW-1:0] mul_b;
    logic signed [LDA_PW-1:0] mul_p, prod_bias;
    logic signed [LDA_AW-1:0] prod_rnd;

    // Scale and normalize
    logic [5:0]               ksh;
    logic [63:0]              p64, e64;
    logic                     eflag;
    logic [LDA_SW-1:0]        m;
    logic [LDA_SW:0]          s_inc;
    logic signed [LDA_AW-1:0] num;
    logic [LDA_SW-1:0]        den_w;
    logic [29:0]              mag;
    logic [63:0]              dvd;

    // Divider, two bits per cycle
    logic [32:0]              rem_a, rem_b;
    logic                     ge_a, ge_b;
    logic [31:0]              rem_a2, rem_b2;

    // Final
    logic signed [LDA_AW-1:0]   v, corr;
    logic signed [LDA_SUMW-1:0] sum_w;
    logic signed [W-1:0]        res;

    assign out_free = !r_out_valid || i_pop;
    assign emit     = r_kind != KIND_ACC;
    assign o_empty  = !r_out_valid;
    assign o_out    = r_out;

    // Order accumulate operands against the running sum
    always_comb begin
        if (r_kind == KIND_PAIR) begin
            n_hi = r_hi;
            n_lo = r_lo;
        end else if (r_sum >= r_hi) begin
            n_hi = r_sum;
            n_lo = r_hi;
        end else begin
            n_hi = r_hi;
            n_lo = r_sum;
        end
        bypass = n_lo == LDA_NEUTRAL;
    end

    // Round the distance to the nearest integer, ties to even
    always_comb begin
        diff   = {r_hi[W-1], r_hi} - {r_lo[W-1], r_lo};
        q      = diff[W:F];
        rem    = diff[F-1:0];
        rnd_up = (rem > LDA_HALF) || ((rem == LDA_HALF) && q[0]);
        k      = {1'b0, q} + LDA_KW'(rnd_up);
        fdiff  = {k, {F{1'b0}}} - (LDA_KW+F)'(diff);
        fs     = signed'(fdiff[F:0]);
    end

    always_comb begin
        mul_a = r_acc;
        mul_b = r_f;
        if (r_state == ST_EXP) begin
            mul_a = (r_cnt == '0) ? LDA_EXP_C0 : r_acc;
            mul_b = r_f;
        end else begin
            unique case (r_cnt)
                4'd0: begin
                    mul_a = LDA_AW'(r_y);
                    mul_b = r_y;
                end
                4'd1: begin
                    mul_a = LDA_LOG_C0;
                    mul_b = r_y2;
                end
                4'd2: begin
                    mul_a = r_acc;
                    mul_b = r_y2;
                end
                default: begin
                    mul_a = r_acc;
                    mul_b = r_y;
                end
            endcase
        end
        mul_p     = mul_a * mul_b;
        prod_bias = r_prod + LDA_MUL_BIAS;
        prod_rnd  = LDA_AW'(prod_bias >>> LDA_IB);
    end

    always_comb begin
        ksh   = (r_k > LDA_KW'(62)) ? 6'd62 : r_k[5:0];
        p64   = 64'(r_acc);
        e64   = (r_k == '0) ? p64 : ((p64 + (64'd1 << (ksh - 6'd1))) >> ksh);
        eflag = r_s >= LDA_SQRT2;
        s_inc = {1'b0, r_s} + 1'b1;
        m     = eflag ? s_inc[LDA_SW:1] : r_s;
        num   = signed'(LDA_AW'(m)) - LDA_ONE_S;
        den_w = m + LDA_ONE;
        mag   = (num < 0) ? 30'(-num) : num[29:0];
        dvd   = (64'(mag) << LDA_IB) + 64'(den_w[31:1]);
    end

    always_comb begin
        rem_a  = {r_rem, r_dvd[31]};
        ge_a   = rem_a >= {1'b0, r_den};
        rem_a2 = ge_a ? 32'(rem_a - {1'b0, r_den}) : rem_a[31:0];
        rem_b  = {rem_a2, r_dvd[30]};
        ge_b   = rem_b >= {1'b0, r_den};
        rem_b2 = ge_b ? 32'(rem_b - {1'b0, r_den}) : rem_b[31:0];
    end

    always_comb begin
        v     = r_acc + (r_eflag ? LDA_ONE_S : '0);
        corr  = (v + LDA_OUT_BIAS) >>> (LDA_IB - F);
        sum_w = LDA_SUMW'(r_hi) + LDA_SUMW'(corr);
        if (r_bypass) begin
            res = r_hi;
        end else if (sum_w > LDA_SUMW'(LDA_MAXCODE)) begin
            res = LDA_MAXCODE;
        end else if (sum_w < LDA_SUMW'(LDA_MINCODE)) begin
            res = LDA_MINCODE;
        end else begin
            res = W'(sum_w);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (!i_task_empty) n_state = ST_PREP;
            ST_PREP:  n_state = bypass ? ST_FIN : ST_RED;
            ST_RED:   n_state = ST_EXP;
            ST_EXP: begin
                if (r_phase && (r_cnt == LDA_CNT_W'(LDA_EXP_STEPS - 1))) n_state = ST_SCALE;
            end
            ST_SCALE: n_state = ST_NORM;
            ST_NORM:  n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == LDA_CNT_W'(LDA_DIV_CYCLES - 1)) n_state = ST_LOG;
            end
            ST_LOG: begin
                if (r_phase && (r_cnt == LDA_CNT_W'(LDA_LOG_STEPS - 1))) n_state = ST_FIN;
            end
            ST_FIN:   n_state = emit ? ST_EMIT : ST_IDLE;
            ST_EMIT:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_task_pop = (r_state == ST_IDLE) && !i_task_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= LDA_NEUTRAL;
            r_out_valid <= 1'b0;
            r_phase     <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;
            // Load a new result, else drop the popped one
            if ((r_state == ST_EMIT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_RED, ST_NORM: begin
                    r_cnt   <= '0;
                    r_phase <= 1'b0;
                end
                ST_EXP, ST_LOG: begin
                    r_phase <= !r_phase;
                    if (r_phase) begin
                        r_cnt <= (n_state == r_state) ? r_cnt + 1'b1 : '0;
                    end
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                end
                ST_FIN: begin
                    if (r_kind == KIND_ACC) begin
                        r_sum <= res;
                    end else if (r_kind == KIND_ACC_LAST) begin
                        r_sum <= LDA_NEUTRAL;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_kind <= i_task.kind;
                r_hi   <= i_task.hi;
                r_lo   <= i_task.lo;
            end
            ST_PREP: begin
                r_hi     <= n_hi;
                r_lo     <= n_lo;
                r_bypass <= bypass;
            end
            ST_RED: begin
                r_k <= k;
                r_f <= LDA_BW'(fs) <<< (LDA_IB - F);
            end
            ST_EXP: begin
                if (!r_phase) begin
                    r_prod <= mul_p;
                end else begin
                    r_acc <= prod_rnd + lda_exp_addend(r_cnt);
                end
            end
            ST_SCALE: begin
                r_s <= LDA_ONE + e64[LDA_SW-1:0];
            end
            ST_NORM: begin
                r_eflag <= eflag;
                r_neg   <= num < 0;
                r_den   <= den_w[31:0];
                r_rem   <= dvd[63:32];
                r_dvd   <= dvd[31:0];
                r_quo   <= '0;
            end
            ST_DIV: begin
                r_rem <= rem_b2;
                r_dvd <= {r_dvd[29:0], 2'b00};
                r_quo <= {r_quo[29:0], ge_a, ge_b};
                if (r_cnt == LDA_CNT_W'(LDA_DIV_CYCLES - 1)) begin
                    r_y <= r_neg ? -signed'({r_quo[29:0], ge_a, ge_b})
                                 : signed'({r_quo[29:0], ge_a, ge_b});
                end
            end
            ST_LOG: begin
                if (!r_phase) begin
                    r_prod <= mul_p;
                end else begin
                    unique case (r_cnt)
                        4'd0:    r_y2  <= LDA_BW'(prod_rnd);
                        4'd1:    r_acc <= prod_rnd + LDA_LOG_C1;
                        4'd2:    r_acc <= prod_rnd + LDA_LOG_C2;
                        default: r_acc <= prod_rnd;
                    endcase
                end
            end
            ST_FIN: begin
                r_res <= res;
            end
            ST_EMIT: begin
                if (out_free) begin
                    r_out.result_value <= r_res;
                    r_out.is_sum       <= r_kind == KIND_ACC_LAST;
                end
            end
            default: begin
            end
        endcase
    end

    `LDA_ASSERT_IMP(a_pop_only_idle, o_task_pop, r_state == ST_IDLE, "task taken while busy")
    `LDA_ASSERT_NXT(a_sum_cleared, (r_state == ST_FIN) && (r_kind == KIND_ACC_LAST), r_sum == LDA_NEUTRAL, "running sum not cleared after run end")
    `LDA_ASSERT_NXT(a_emit_loads, (r_state == ST_EMIT) && out_free, r_out_valid && (r_out.result_value == $past(r_res)), "result not loaded on emit")

endmodule

>>> design/log_domain_add_accumulate.sv
// Log-domain adder: each request returns log2(2^a + 2^b) in signed Q7.16, computed as
// max + log2(1 + 2^-(max-min)); the most negative code stands for minus infinity and
// results saturate at the largest code. A pairwise request (op 0) always yields one
// result; an accumulate request (op 1) folds a into a running sum and yields the sum,
// flagged is_sum, only when last is set, after which the sum restarts at minus infinity.
// A front stage orders pairwise operands and drops the request into a short queue, so push
// keeps working while the back end computes, until the queue fills. The back end works one
// request at a time on one shared 34x32 multiplier, with five Horner steps for the
// exponential, four for the logarithm and a radix-4 divider between them; the arithmetic
// is skipped when an operand is minus infinity. Accumulate requests chain through the
// running sum, so each depends on the one before it. A finished result waits in an
// output register until popped.
module log_domain_add_accumulate
    import lda_pkg::*;
#(
    parameter int QUEUE_DEPTH = LDA_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_in_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_out_item
);

    logic  q_full;
    logic  q_empty;
    logic  task_push;
    logic  task_pop;
    t_task task_in;
    t_task task_out;

    // Classify and order each request
    lda_front u_front (
        .i_push      (push),
        .i_item      (i_in_item),
        .i_q_full    (q_full),
        .o_full      (full),
        .o_task_push (task_push),
        .o_task      (task_in)
    );

    // Decouple intake from the arithmetic
    lda_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (task_push),
        .i_data  (task_in),
        .o_full  (q_full),
        .i_pop   (task_pop),
        .o_data  (task_out),
        .o_empty (q_empty)
    );

    // Compute, accumulate and hold the result
    lda_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_task       (task_out),
        .i_task_empty (q_empty),
        .o_task_pop   (task_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out        (o_out_item)
    );

endmodule

>>> sim/tb_log_domain_add_accumulate.sv
`timescale 1ns / 100ps

module tb_log_domain_add_accumulate;
    import lda_pkg::*;

    // Cycles without any accepted request or result before the run is declared hung.
    // It is set well above the time the slowest request takes, so it leaves a wide margin.
    localparam int IDLE_LIMIT  = 4000;
    // Settle time after the last expected result has come back.
    localparam int DRAIN_WAIT  = 200;

    localparam longint ONE_Q30 = 64'sd1 << 30;
    localparam longint SQRT2_Q30 = 64'sd1518500250;
    localparam longint NEUTRAL_V = -(64'sd1 << (LDA_VALUE_WIDTH - 1));
    localparam longint MAXCODE_V = (64'sd1 << (LDA_VALUE_WIDTH - 1)) - 1;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    t_in_item  i_in_item = '0;
    logic      empty;
    logic      pop = 1'b0;
    t_out_item o_out_item;

    // Expected results, oldest first
    t_out_item expected_q[$];
    // Predicted running sum of the accumulate chain
    longint    acc_sum = NEUTRAL_V;
    int        error_count = 0;
    int        idle_cycles = 0;

    // Sender burst shaping
    int        burst_left = 0;

    longint    exp_coef[6] = '{64'sd1438308, 64'sd10383914, 64'sd59596329,
                               64'sd257936533, 64'sd744261139, 64'sd1073741880};

    log_domain_add_accumulate uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Fixed-point math of the block, in Q.30 on 64-bit integers
    // ------------------------------------------------------------------

    // Shift right by s, rounding half toward plus infinity
    function automatic longint round_shift(input longint v, input int s);
        return (v + (64'sd1 << (s - 1))) >>> s;
    endfunction

    // 2^(-r) in Q.30 for r >= 0 in Q.16
    function automatic longint pow2_neg(input longint r);
        longint q;
        longint rem;
        longint k;
        longint f;
        longint p;
        q   = r >>> LDA_FRAC_BITS;
        rem = r & ((64'sd1 << LDA_FRAC_BITS) - 1);
        k   = q;
        // round to nearest, ties to even
        if (rem > (64'sd1 << (LDA_FRAC_BITS - 1)) ||
            (rem == (64'sd1 << (LDA_FRAC_BITS - 1)) && q[0])) begin
            k = q + 1;
        end
        f = ((k <<< LDA_FRAC_BITS) - r) * (64'sd1 << (30 - LDA_FRAC_BITS));
        p = exp_coef[0];
        for (int i = 1; i < 6; i++) begin
            p = round_shift(p * f, 30) + exp_coef[i];
        end
        if (k == 0) begin
            return p;
        end
        if (k > 62) begin
            k = 62;
        end
        return round_shift(p, int'(k));
    endfunction

    // log2(s) in Q.30 for s >= 1.0 in Q.30
    function automatic longint log2_q30(input longint s);
        bit     upper;
        longint m;
        longint num;
        longint den;
        longint mag;
        longint y;
        longint y2;
        longint lr;
        upper = (s >= SQRT2_Q30);
        m     = upper ? round_shift(s, 1) : s;
        num   = m - ONE_Q30;
        den   = m + ONE_Q30;
        mag   = (num < 0) ? -num : num;
        y     = ((mag <<< 30) + den / 2) / den;
        if (num < 0) begin
            y = -y;
        end
        y2 = round_shift(y * y, 30);
        lr = 64'sd641277395;
        lr = round_shift(lr * y2, 30) + 64'sd1032428977;
        lr = round_shift(lr * y2, 30) + 64'sd3098164970;
        lr = round_shift(lr * y, 30);
        return upper ? lr + ONE_Q30 : lr;
    endfunction

    // log2(2^x + 2^y) on Q7.16 codes, neutral-aware and saturated
    function automatic longint log_sum(input longint x, input longint y);
        longint hi;
        longint lo;
        longint corr;
        longint res;
        hi = (x > y) ? x : y;
        lo = (x > y) ? y : x;
        if (lo == NEUTRAL_V) begin
            return hi;
        end
        corr = round_shift(log2_q30(ONE_Q30 + pow2_neg(hi - lo)), 30 - LDA_FRAC_BITS);
        res  = hi + corr;
        if (res > MAXCODE_V) begin
            res = MAXCODE_V;
        end
        if (res < NEUTRAL_V + 1) begin
            res = NEUTRAL_V + 1;
        end
        return res;
    endfunction

    // Update the predicted state with one accepted request and queue what it yields
    task automatic predict_request(input t_in_item req);
        t_out_item res;
        if (req.op == 1'b0) begin
            res.result_value = LDA_VALUE_WIDTH'(log_sum(longint'(req.a), longint'(req.b)));
            res.is_sum       = 1'b0;
            expected_q.push_back(res);
        end else begin
            acc_sum = log_sum(acc_sum, longint'(req.a));
            if (req.last) begin
                res.result_value = LDA_VALUE_WIDTH'(acc_sum);
                res.is_sum       = 1'b1;
                expected_q.push_back(res);
                acc_sum = NEUTRAL_V;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Drive one request and hold it until the block takes it. Bursts of random
    // length alternate with random gaps; within a burst push stays high.
    task automatic send_request(input t_in_item req);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_item <= req;
        push      <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (full);
        predict_request(req);
    endtask

    function automatic t_in_item make_request(input bit op, input logic [23:0] a,
                                              input logic [23:0] b, input bit last);
        t_in_item req;
        req.op   = op;
        req.a    = a;
        req.b    = b;
        req.last = last;
        return req;
    endfunction

    // Operand code: mostly random, with extremes and neutral mixed in
    function automatic logic [23:0] pick_code();
        case ($urandom_range(0, 11))
            0:       return LDA_NEUTRAL;
            1:       return LDA_MAXCODE;
            2:       return LDA_MINCODE;
            3:       return '0;
            default: return 24'($urandom);
        endcase
    endfunction

    // Code near base; small gaps are where the correction term matters
    function automatic logic [23:0] near_code(input logic [23:0] base);
        int    sh;
        logic [23:0] d;
        sh = $urandom_range(0, 22);
        d  = 24'($urandom_range(0, (1 << sh)));
        return $urandom_range(0, 1) ? base + d : base - d;
    endfunction

    // ------------------------------------------------------------------
    // Result side: stall pattern and checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    int stall_mode = 0;
    int stall_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value=%0d is_sum=%0b",
                                              o_out_item.result_value, o_out_item.is_sum));
                end else begin
                    if (o_out_item.result_value !== expected_q[0].result_value) begin
                        report_mismatch($sformatf("result_value got %0d want %0d",
                                                  o_out_item.result_value,
                                                  expected_q[0].result_value));
                    end
                    if (o_out_item.is_sum !== expected_q[0].is_sum) begin
                        report_mismatch($sformatf("is_sum got %0b want %0b",
                                                  o_out_item.is_sum, expected_q[0].is_sum));
                    end
                    void'(expected_q.pop_front());
                end
            end
            // Switch stall behavior when the current stretch runs out
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(50, 400);
            end
            stall_left--;
            case (stall_mode)
                0:       pop <= 1'b1;
                1:       pop <= $urandom_range(0, 1);
                2:       pop <= ($urandom_range(0, 7) == 0);
                default: pop <= ($urandom_range(0, 31) != 0);
            endcase
        end
    end

    // Watchdog: count cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_log_domain_add_accumulate: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extremes, neutral handling, rounding ties and saturation for pairwise adds
    task automatic test_pair_corners();
        send_request(make_request(1'b0, LDA_NEUTRAL, LDA_NEUTRAL, 1'b0));
        send_request(make_request(1'b0, LDA_NEUTRAL, 24'h012345, 1'b1));
        send_request(make_request(1'b0, LDA_MAXCODE, LDA_NEUTRAL, 1'b0));
        send_request(make_request(1'b0, LDA_MAXCODE, LDA_MAXCODE, 1'b0));
        send_request(make_request(1'b0, LDA_MINCODE, LDA_MINCODE, 1'b1));
        send_request(make_request(1'b0, LDA_MAXCODE, LDA_MINCODE, 1'b0));
        send_request(make_request(1'b0, 24'h0, 24'h0, 1'b0));
        // exact half-way gaps: 0.5 rounds down to even, 1.5 rounds up to even
        send_request(make_request(1'b0, 24'h008000, 24'h0, 1'b0));
        send_request(make_request(1'b0, 24'h0, 24'h018000, 1'b0));
        send_request(make_request(1'b0, 24'hFE8000, 24'hFF0000, 1'b0));
        // gap above 62 clamps the scale shift
        send_request(make_request(1'b0, 24'h400000, 24'hC00000, 1'b0));
        send_request(make_request(1'b0, 24'hFFFFFF, 24'h000001, 1'b1));
    endtask

    // Accumulate runs: empty-ish runs, saturation, neutral-only and short chains
    task automatic test_accumulate_corners();
        send_request(make_request(1'b1, LDA_NEUTRAL, 24'hFFFFFF, 1'b1));
        send_request(make_request(1'b1, LDA_MAXCODE, 24'h0, 1'b0));
        send_request(make_request(1'b1, LDA_MAXCODE, 24'h0, 1'b1));
        send_request(make_request(1'b1, LDA_NEUTRAL, 24'h0, 1'b0));
        send_request(make_request(1'b1, LDA_MINCODE, 24'h0, 1'b1));
        send_request(make_request(1'b1, 24'h010000, 24'h0, 1'b0));
        // pairwise in the middle of a run leaves the sum alone
        send_request(make_request(1'b0, 24'h020000, 24'h030000, 1'b0));
        send_request(make_request(1'b1, 24'h010000, LDA_NEUTRAL, 1'b0));
        send_request(make_request(1'b1, 24'hFF8000, 24'h0, 1'b1));
    endtask

    // Random pairwise adds, often with operands close to each other
    task automatic test_random_pairs(input int count);
        logic [23:0] a;
        logic [23:0] b;
        for (int i = 0; i < count; i++) begin
            a = pick_code();
            b = $urandom_range(0, 2) ? near_code(a) : pick_code();
            send_request(make_request(1'b0, a, b, $urandom_range(0, 1)));
        end
    endtask

    // Random accumulate runs ending in last, with stray pairwise requests between
    task automatic test_random_runs(input int count);
        int          sent;
        int          len;
        logic [23:0] base;
        sent = 0;
        while (sent < count) begin
            len  = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 6);
            base = pick_code();
            for (int j = 0; j < len; j++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_request(make_request(1'b0, pick_code(), pick_code(),
                                              $urandom_range(0, 1)));
                end else begin
                    send_request(make_request(1'b1,
                                              $urandom_range(0, 2) ? near_code(base)
                                                                   : pick_code(),
                                              24'($urandom), j == len - 1));
                end
                sent++;
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_pair_corners();
        test_accumulate_corners();
        test_random_pairs(800);
        test_random_runs(950);
        push <= 1'b0;

        // hold until every expected result has been popped, then let things settle
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (error_count == 0) begin
            $display("tb_log_domain_add_accumulate: PASS");
        end else begin
            $display("tb_log_domain_add_accumulate: FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/lda_pkg.sv
design/lda_front.sv
design/lda_queue.sv
design/lda_back.sv
design/log_domain_add_accumulate.sv
sim/tb_log_domain_add_accumulate.sv
